>>> rtl/core/cssms_pkg.sv
// ----------------------------------------------------------------------------
// Clock and matrix scanner package
// Shared types, reset values and decode functions for the digital clock with
// multiplexed seven-segment display and LED matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cssms_pkg;

	localparam int NUM_DIGITS  = 4;
	localparam int NUM_COLUMNS = 8;
	localparam int NUM_TIMERS  = 4;
	localparam int PERIOD_W    = 10;
	localparam int DIGIT_POS_W = $clog2(NUM_DIGITS);
	localparam int COL_POS_W   = $clog2(NUM_COLUMNS);
	localparam int IMAGE_W     = 64;
	localparam int CFG_INDEX_W = 3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_SET  = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DIGIT_SCAN  = 3'd0,
		CFG_BLINK       = 3'd1,
		CFG_SECOND      = 3'd2,
		CFG_MATRIX_SCAN = 3'd3,
		CFG_IMAGE       = 3'd4
	} cfg_index_t;

	typedef enum int {
		TMR_DIGIT  = 0,
		TMR_BLINK  = 1,
		TMR_SECOND = 2,
		TMR_COLUMN = 3
	} timer_sel_t;

	localparam logic [PERIOD_W-1:0] RST_DIGIT_SCAN  = 10'd10;
	localparam logic [PERIOD_W-1:0] RST_BLINK       = 10'd100;
	localparam logic [PERIOD_W-1:0] RST_SECOND      = 10'd100;
	localparam logic [PERIOD_W-1:0] RST_MATRIX_SCAN = 10'd1;
	localparam logic [IMAGE_W-1:0]  RST_IMAGE       = 64'h0000_3E48_8848_3E00;

	localparam logic [4:0] RST_HOURS   = 5'd15;
	localparam logic [5:0] RST_MINUTES = 6'd8;
	localparam logic [5:0] RST_SECONDS = 6'd50;

	localparam logic [6:0] SEG_BLANK = 7'h7F;

	typedef logic [NUM_TIMERS-1:0][PERIOD_W-1:0] periods_t;
	typedef logic [NUM_DIGITS-1:0][3:0]          digits_t;

	typedef struct packed {
		logic       kind;
		logic [4:0] set_hour;
		logic [5:0] set_minute;
		logic [5:0] set_second;
	} in_item_t;

	typedef struct packed {
		logic [6:0] segments;
		logic [3:0] digit_enables;
		logic       dot_led;
		logic       red_led;
		logic [7:0] column_enables;
		logic [7:0] row_lines;
	} out_item_t;

	typedef struct packed {
		logic digit;
		logic blink;
		logic second;
		logic column;
	} fire_t;

	// Active-low common-anode pattern, segment a in bit 0.
	function automatic logic [6:0] seg_decode(logic [3:0] v);
		logic [6:0] s;
		begin
			case (v)
				4'd0: s = 7'h40;
				4'd1: s = 7'h79;
				4'd2: s = 7'h24;
				4'd3: s = 7'h30;
				4'd4: s = 7'h19;
				4'd5: s = 7'h12;
				4'd6: s = 7'h02;
				4'd7: s = 7'h78;
				4'd8: s = 7'h00;
				4'd9: s = 7'h10;
				default: s = SEG_BLANK;
			endcase
			return s;
		end
	endfunction

	// Splits a value below 64 into its tens digit (upper nibble) and ones digit.
	function automatic logic [7:0] bcd_split(logic [5:0] v);
		logic [3:0] t;
		logic [5:0] r;
		begin
			t = 4'd0;
			r = v;
			for (int i = 1; i <= 6; i++) begin
				if (v >= 6'(10 * i)) begin
					t = 4'(i);
					r = v - 6'(10 * i);
				end
			end
			return {t, r[3:0]};
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/cssms_timers.sv
// ----------------------------------------------------------------------------
// Tick timers
// Four down-counters that flag expiry and reload from their periods.
// ----------------------------------------------------------------------------
`default_nettype none

module cssms_timers (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire cssms_pkg::periods_t periods,
	output cssms_pkg::fire_t        expire
);

	logic [cssms_pkg::NUM_TIMERS-1:0][cssms_pkg::PERIOD_W-1:0] count_q;
	logic [cssms_pkg::NUM_TIMERS-1:0]                          hit;

	always_comb begin
		for (int i = 0; i < cssms_pkg::NUM_TIMERS; i++) begin
			hit[i] = (count_q[i] <= cssms_pkg::PERIOD_W'(1));
		end
		expire.digit  = hit[cssms_pkg::TMR_DIGIT];
		expire.blink  = hit[cssms_pkg::TMR_BLINK];
		expire.second = hit[cssms_pkg::TMR_SECOND];
		expire.column = hit[cssms_pkg::TMR_COLUMN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q[cssms_pkg::TMR_DIGIT]  <= cssms_pkg::RST_DIGIT_SCAN;
			count_q[cssms_pkg::TMR_BLINK]  <= cssms_pkg::RST_BLINK;
			count_q[cssms_pkg::TMR_SECOND] <= cssms_pkg::RST_SECOND;
			count_q[cssms_pkg::TMR_COLUMN] <= cssms_pkg::RST_MATRIX_SCAN;
		end else if (step) begin
			for (int i = 0; i < cssms_pkg::NUM_TIMERS; i++) begin
				if (hit[i]) begin
					count_q[i] <= periods[i];
				end else begin
					count_q[i] <= count_q[i] - cssms_pkg::PERIOD_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cssms_timekeeper.sv
// ----------------------------------------------------------------------------
// Timekeeper
// Holds hh:mm:ss, loads a set time or advances it on each seconds-timer fire,
// and keeps the BCD digits of hours and minutes.
// ----------------------------------------------------------------------------
`default_nettype none

module cssms_timekeeper (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              set_en,
	input  wire logic [4:0]        set_hour,
	input  wire logic [5:0]        set_minute,
	input  wire logic [5:0]        set_second,
	input  wire logic              sec_fire,
	output cssms_pkg::digits_t     digits
);

	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;
	cssms_pkg::digits_t digits_q;

	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [4:0] hours_d;
	logic [5:0] minutes_d;
	logic [5:0] seconds_d;
	logic [7:0] hour_bcd;
	logic [7:0] min_bcd;

	always_comb begin
		sec_inc   = {1'b0, seconds_q} + 7'd1;
		seconds_d = 6'(sec_inc);
		min_inc   = {1'b0, minutes_q};
		if (sec_inc >= 7'd60) begin
			seconds_d = 6'd0;
			min_inc   = {1'b0, minutes_q} + 7'd1;
		end
		minutes_d = 6'(min_inc);
		hour_inc  = {1'b0, hours_q};
		if (min_inc >= 7'd60) begin
			minutes_d = 6'd0;
			hour_inc  = {1'b0, hours_q} + 6'd1;
		end
		hours_d = 5'(hour_inc);
		if (hour_inc >= 6'd24) begin
			hours_d = 5'd0;
		end
		if (set_en) begin
			hours_d   = set_hour;
			minutes_d = set_minute;
			seconds_d = set_second;
		end
		hour_bcd = cssms_pkg::bcd_split({1'b0, hours_d});
		min_bcd  = cssms_pkg::bcd_split(minutes_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q     <= cssms_pkg::RST_HOURS;
			minutes_q   <= cssms_pkg::RST_MINUTES;
			seconds_q   <= cssms_pkg::RST_SECONDS;
			digits_q[0] <= 4'd1;
			digits_q[1] <= 4'd5;
			digits_q[2] <= 4'd0;
			digits_q[3] <= 4'd8;
		end else if (set_en || sec_fire) begin
			hours_q     <= hours_d;
			minutes_q   <= minutes_d;
			seconds_q   <= seconds_d;
			digits_q[0] <= hour_bcd[7:4];
			digits_q[1] <= hour_bcd[3:0];
			digits_q[2] <= min_bcd[7:4];
			digits_q[3] <= min_bcd[3:0];
		end
	end

	assign digits = digits_q;

endmodule

`default_nettype wire

>>> rtl/core/cssms_scanner.sv
// ----------------------------------------------------------------------------
// Display scanner
// Drives the digit scan, the LED and dot blink and the matrix column scan.
// The line registers form the result register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module cssms_scanner (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire cssms_pkg::fire_t                    fire,
	input  wire cssms_pkg::digits_t                  digits,
	input  wire logic [cssms_pkg::IMAGE_W-1:0]       image,
	output cssms_pkg::out_item_t                     lines
);

	logic [cssms_pkg::DIGIT_POS_W-1:0] digit_pos_q;
	logic [cssms_pkg::COL_POS_W-1:0]   col_pos_q;
	cssms_pkg::out_item_t              lines_q;

	logic [7:0] col_code;
	logic [7:0] col_rev;

	always_comb begin
		col_code = image[{col_pos_q, 3'b000} +: 8];
		for (int i = 0; i < 8; i++) begin
			col_rev[7 - i] = col_code[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_pos_q <= '0;
			col_pos_q   <= '0;
			lines_q     <= '0;
		end else begin
			if (fire.digit) begin
				lines_q.segments      <= cssms_pkg::seg_decode(digits[digit_pos_q]);
				lines_q.digit_enables <= 4'(~(4'b0001 << digit_pos_q));
				if (digit_pos_q == cssms_pkg::DIGIT_POS_W'(cssms_pkg::NUM_DIGITS - 1)) begin
					digit_pos_q <= '0;
				end else begin
					digit_pos_q <= digit_pos_q + cssms_pkg::DIGIT_POS_W'(1);
				end
			end
			if (fire.blink) begin
				lines_q.dot_led <= ~lines_q.dot_led;
				lines_q.red_led <= ~lines_q.red_led;
			end
			if (fire.column) begin
				lines_q.column_enables <= 8'(~(8'b0000_0001 << col_pos_q));
				lines_q.row_lines      <= ~col_rev;
				if (col_pos_q == cssms_pkg::COL_POS_W'(cssms_pkg::NUM_COLUMNS - 1)) begin
					col_pos_q <= '0;
				end else begin
					col_pos_q <= col_pos_q + cssms_pkg::COL_POS_W'(1);
				end
			end
		end
	end

	assign lines = lines_q;

endmodule

`default_nettype wire

>>> rtl/core/clock_seven_segment_matrix_scanner_unit.sv
// ----------------------------------------------------------------------------
// Digital clock with seven-segment and LED matrix scanner
// Flow: items pass the single input register stage, then the line registers.
// Throughput: one item per cycle while the output is not stalled.
// Reset: asynchronous; timers, time of day, scan positions, lines and
// configuration registers return to their power-up values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_seven_segment_matrix_scanner_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire cssms_pkg::in_item_t                   in_item,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output cssms_pkg::out_item_t                       out_item,
	input  wire logic                                  cfg_we,
	input  wire logic [cssms_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [cssms_pkg::IMAGE_W-1:0]         cfg_data
);

	cssms_pkg::periods_t              periods_q;
	logic [cssms_pkg::IMAGE_W-1:0]    image_q;

	logic                             valid_s1;
	cssms_pkg::in_item_t              item_s1;
	logic                             out_valid_q;

	logic                             advance;
	logic                             tick_step;
	logic                             set_step;
	cssms_pkg::fire_t                 expire;
	cssms_pkg::fire_t                 fire;
	cssms_pkg::digits_t               digits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periods_q[cssms_pkg::TMR_DIGIT]  <= cssms_pkg::RST_DIGIT_SCAN;
			periods_q[cssms_pkg::TMR_BLINK]  <= cssms_pkg::RST_BLINK;
			periods_q[cssms_pkg::TMR_SECOND] <= cssms_pkg::RST_SECOND;
			periods_q[cssms_pkg::TMR_COLUMN] <= cssms_pkg::RST_MATRIX_SCAN;
			image_q                          <= cssms_pkg::RST_IMAGE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cssms_pkg::CFG_DIGIT_SCAN:
					periods_q[cssms_pkg::TMR_DIGIT] <= cfg_data[cssms_pkg::PERIOD_W-1:0];
				cssms_pkg::CFG_BLINK:
					periods_q[cssms_pkg::TMR_BLINK] <= cfg_data[cssms_pkg::PERIOD_W-1:0];
				cssms_pkg::CFG_SECOND:
					periods_q[cssms_pkg::TMR_SECOND] <= cfg_data[cssms_pkg::PERIOD_W-1:0];
				cssms_pkg::CFG_MATRIX_SCAN:
					periods_q[cssms_pkg::TMR_COLUMN] <= cfg_data[cssms_pkg::PERIOD_W-1:0];
				cssms_pkg::CFG_IMAGE:
					image_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign tick_step = advance && (item_s1.kind == cssms_pkg::KIND_TICK);
	assign set_step  = advance && (item_s1.kind == cssms_pkg::KIND_SET);

	always_comb begin
		fire.digit  = tick_step && expire.digit;
		fire.blink  = tick_step && expire.blink;
		fire.second = tick_step && expire.second;
		fire.column = tick_step && expire.column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	cssms_timers u_timers (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (tick_step),
		.periods (periods_q),
		.expire  (expire)
	);

	cssms_timekeeper u_timekeeper (
		.clk        (clk),
		.arst_n     (arst_n),
		.set_en     (set_step),
		.set_hour   (item_s1.set_hour),
		.set_minute (item_s1.set_minute),
		.set_second (item_s1.set_second),
		.sec_fire   (fire.second),
		.digits     (digits)
	);

	cssms_scanner u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.digits (digits),
		.image  (image_q),
		.lines  (out_item)
	);

	assign out_valid = out_valid_q;

	// The red LED and the colon dot always toggle together.
	a_led_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.dot_led == out_item.red_led)
		else $error("dot and red LED levels differ");

	// At most one digit is enabled once scanning has begun.
	a_digit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_item.digit_enables == 4'd0) || $onehot(~out_item.digit_enables))
		else $error("more than one digit enabled");

	// At most one matrix column is enabled once scanning has begun.
	a_column_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_item.column_enables == 8'd0) || $onehot(~out_item.column_enables))
		else $error("more than one matrix column enabled");

	// A stalled result keeps the input stage from taking a new item over a full one.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline is blocked");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Clock and matrix scanner testbench
// Drives tick and set-time items through the valid/ready input with random
// gaps and stalls, reprograms the periods and the matrix picture between
// phases, and compares every displayed line state with a cycle-free predictor
// of the digit scan, blink, seconds and column scan timers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import cssms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

	class display_scoreboard;
		bit [PERIOD_W-1:0] period [NUM_TIMERS];
		bit [PERIOD_W-1:0] count [NUM_TIMERS];
		bit [IMAGE_W-1:0]  image;
		bit [4:0]          hours;
		bit [5:0]          minutes;
		bit [5:0]          seconds;
		bit [3:0]          digit [NUM_DIGITS];
		int                digit_pos;
		int                column_pos;
		bit [6:0]          seg;
		bit [3:0]          den;
		bit [7:0]          col;
		bit [7:0]          row;
		bit                red;
		bit                dot;
		bit [6:0]          glyph [10];
		out_item_t         expected_lines [$];
		int                errors;

		function new();
			glyph = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10};
			errors = 0;
			period[TMR_DIGIT] = RST_DIGIT_SCAN;
			period[TMR_BLINK] = RST_BLINK;
			period[TMR_SECOND] = RST_SECOND;
			period[TMR_COLUMN] = RST_MATRIX_SCAN;
			count = period;
			image = RST_IMAGE;
			hours = RST_HOURS;
			minutes = RST_MINUTES;
			seconds = RST_SECONDS;
			load_digits();
			digit_pos = 0;
			column_pos = 0;
			seg = '0;
			den = '0;
			col = '0;
			row = '0;
			red = 1'b0;
			dot = 1'b0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [IMAGE_W-1:0] data);
			case (idx)
				CFG_DIGIT_SCAN: period[TMR_DIGIT] = data[PERIOD_W-1:0];
				CFG_BLINK: period[TMR_BLINK] = data[PERIOD_W-1:0];
				CFG_SECOND: period[TMR_SECOND] = data[PERIOD_W-1:0];
				CFG_MATRIX_SCAN: period[TMR_COLUMN] = data[PERIOD_W-1:0];
				CFG_IMAGE: image = data;
				default: ;
			endcase
		endfunction

		function void load_digits();
			digit[0] = 4'(hours / 10);
			digit[1] = 4'(hours % 10);
			digit[2] = 4'(minutes / 10);
			digit[3] = 4'(minutes % 10);
		endfunction

		// A counter at 0 or 1 fires and reloads; otherwise it counts down.
		function bit expire(timer_sel_t t);
			if (count[t] <= 1) begin
				count[t] = period[t];
				return 1'b1;
			end
			count[t] = count[t] - 1'b1;
			return 1'b0;
		endfunction

		function void note_item(in_item_t it);
			int s;
			int m;
			int h;
			int c;
			bit [7:0] code;
			bit [3:0] v;
			out_item_t e;
			if (it.kind == KIND_SET) begin
				hours = it.set_hour;
				minutes = it.set_minute;
				seconds = it.set_second;
				load_digits();
			end else begin
				if (expire(TMR_DIGIT)) begin
					if (digit_pos < NUM_DIGITS) begin
						v = digit[digit_pos];
						seg = (v < 10) ? glyph[v] : SEG_BLANK;
						den = ~(4'b0001 << digit_pos);
					end else begin
						seg = SEG_BLANK;
						den = '1;
					end
					digit_pos = (digit_pos + 1) % NUM_DIGITS;
				end
				if (expire(TMR_BLINK)) begin
					red = ~red;
					dot = ~dot;
				end
				if (expire(TMR_SECOND)) begin
					s = seconds + 1;
					m = minutes;
					h = hours;
					if (s >= 60) begin
						s = 0;
						m = m + 1;
					end
					if (m >= 60) begin
						m = 0;
						h = h + 1;
					end
					if (h >= 24)
						h = 0;
					seconds = 6'(s);
					minutes = 6'(m);
					hours = 5'(h);
					load_digits();
				end
				if (expire(TMR_COLUMN)) begin
					c = column_pos % 8;
					code = image[8*c +: 8];
					for (int i = 0; i < 8; i++)
						row[7-i] = ~code[i];
					col = ~(8'b0000_0001 << c);
					column_pos = (column_pos + 1) % NUM_COLUMNS;
				end
			end
			e.segments = seg;
			e.digit_enables = den;
			e.dot_led = dot;
			e.red_led = red;
			e.column_enables = col;
			e.row_lines = row;
			expected_lines.push_back(e);
		endfunction

		function void check_lines(out_item_t got);
			out_item_t e;
			if (expected_lines.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result item %h", $time, got);
				return;
			end
			e = expected_lines.pop_front();
			if (got.segments !== e.segments || got.digit_enables !== e.digit_enables ||
			    got.dot_led !== e.dot_led || got.red_led !== e.red_led ||
			    got.column_enables !== e.column_enables || got.row_lines !== e.row_lines) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch seg %h/%h dig %h/%h dot %b/%b red %b/%b col %h/%h row %h/%h (expected/actual)",
						$time, e.segments, got.segments, e.digit_enables, got.digit_enables,
						e.dot_led, got.dot_led, e.red_led, got.red_led,
						e.column_enables, got.column_enables, e.row_lines, got.row_lines);
			end
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_item;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_item;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [IMAGE_W-1:0]     cfg_data;

	display_scoreboard board;
	bit                calm;
	bit                held_off;
	int                accepted;
	int                cycles;

	clock_seven_segment_matrix_scanner_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t tick_item();
		in_item_t it;
		it.kind = KIND_TICK;
		it.set_hour = 5'($urandom);
		it.set_minute = 6'($urandom);
		it.set_second = 6'($urandom);
		return it;
	endfunction

	function automatic in_item_t time_item(bit [4:0] h, bit [5:0] m, bit [5:0] s);
		in_item_t it;
		it.kind = KIND_SET;
		it.set_hour = h;
		it.set_minute = m;
		it.set_second = s;
		return it;
	endfunction

	function automatic in_item_t random_item();
		if ($urandom_range(0, 99) < 85)
			return tick_item();
		if ($urandom_range(0, 1))
			return time_item(5'($urandom), 6'($urandom), 6'($urandom));
		return time_item(5'($urandom_range(20, 23)), 6'($urandom_range(57, 59)),
			6'($urandom_range(55, 59)));
	endfunction

	function automatic logic [IMAGE_W-1:0] random_period();
		int r;
		logic [IMAGE_W-1:0] p;
		r = $urandom_range(0, 99);
		if (r < 60)
			p = IMAGE_W'($urandom_range(0, 4));
		else if (r < 80)
			p = IMAGE_W'($urandom_range(5, 30));
		else if (r < 90)
			p = IMAGE_W'(1023);
		else
			p = IMAGE_W'($urandom_range(0, 1023));
		if ($urandom_range(0, 1))
			p[IMAGE_W-1:PERIOD_W] = (IMAGE_W-PERIOD_W)'({$urandom, $urandom});
		return p;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [IMAGE_W-1:0] digit_v, blink_v, second_v,
		column_v, image_v, input bit poke_unused);
		logic [IMAGE_W-1:0] vals [5];
		cfg_index_t order [5];
		vals = '{digit_v, blink_v, second_v, column_v, image_v};
		order = '{CFG_DIGIT_SCAN, CFG_BLINK, CFG_SECOND, CFG_MATRIX_SCAN, CFG_IMAGE};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			board.write_register(order[i], vals[i]);
		end
		if (poke_unused) begin
			vals[0] = {$urandom, $urandom};
			cfg_index <= CFG_UNUSED;
			cfg_data <= vals[0];
			@(posedge clk);
			board.write_register(CFG_UNUSED, vals[0]);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.note_item(in_item);
				accepted++;
			end
			if (out_valid && out_ready)
				board.check_lines(out_item);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** clock_seven_segment_matrix_scanner_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held_off && accepted >= 300) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		int n;
		board = new();
		calm = 1'b0;
		held_off = 1'b0;
		accepted = 0;
		cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DIGIT_SCAN;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-up periods: the digit scan first fires on the tenth tick.
		repeat (10) send_item(tick_item());
		wait_idle();

		// A zero seconds period advances the time on every tick once the seconds counter has reloaded.
		apply_settings(1, 2, 0, 1, 64'h8142_2418_0FF0_A55A, 1'b1);
		send_item(time_item(23, 59, 58));
		repeat (3) send_item(tick_item());
		send_item(time_item(31, 63, 63));
		send_item(tick_item());
		send_item(time_item(0, 0, 0));
		send_item(tick_item());
		send_item(time_item(23, 63, 0));
		send_item(tick_item());
		send_item(time_item(9, 59, 59));
		send_item(tick_item());
		send_item(time_item(19, 59, 59));
		send_item(tick_item());
		send_item(time_item(31, 0, 0));
		send_item(tick_item());
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			calm = (p % 3 == 2);
			if (p == 0)
				apply_settings('1, '1, '1, '1, '1, 1'b0);
			else if (p == 1)
				apply_settings(0, 0, 0, 0, 0, 1'b1);
			else
				apply_settings(random_period(), random_period(), random_period(),
					random_period(), {$urandom, $urandom}, 1'($urandom));
			n = (p == 0) ? 40 : 125;
			repeat (n) send_item(random_item());
			wait_idle();
		end

		calm = 1'b0;
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("** clock_seven_segment_matrix_scanner_unit: PASSED **");
		else
			$display("** clock_seven_segment_matrix_scanner_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
